// ----- rtl/largest_empty_square_finder_defines.svh -----
// Assertion macros used by the checker file.
// No dependencies.
`ifndef LARGEST_EMPTY_SQUARE_FINDER_DEFINES_SVH
`define LARGEST_EMPTY_SQUARE_FINDER_DEFINES_SVH

// same-cycle implication
`define LESF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define LESF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- rtl/lesf_pkg.sv -----
// Shared types and constants of the largest empty square finder.
// No dependencies.
package lesf_pkg;

   localparam int MAX_COLS = 1024;
   localparam int MAX_ROWS = 1024;

   localparam int COL_W   = $clog2(MAX_COLS);
   localparam int ROW_W   = $clog2(MAX_ROWS);
   localparam int CCW     = $clog2(MAX_COLS + 1);
   localparam int RCW     = $clog2(MAX_ROWS + 1);
   localparam int MIN_DIM = (MAX_COLS < MAX_ROWS) ? MAX_COLS : MAX_ROWS;
   localparam int SCORE_W = $clog2(MIN_DIM + 1);

   localparam int CELL_W = 8;
   localparam int CSR_W  = 11;

   localparam logic [CELL_W-1:0] OBSTACLE_RESET = 8'd111;
   localparam logic [CSR_W-1:0]  LENGTH_RESET   = 11'd1024;
   localparam logic [CSR_W-1:0]  COUNT_RESET    = 11'd1024;

   typedef enum logic [1:0] {
      REG_OBSTACLE   = 2'd0,
      REG_ROW_LENGTH = 2'd1,
      REG_ROW_COUNT  = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [CELL_W-1:0] obstacle;
      logic [CCW-1:0]    cols;
      logic [RCW-1:0]    rows;
      logic              restart;
   } cfg_type;

   typedef struct packed {
      logic               valid;
      logic [SCORE_W-1:0] size;
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   col;
   } res_type;

endpackage

// ----- rtl/lesf_core.sv -----
// Scoring pipeline: raster counters, previous-row line store, best square.
// Depends on lesf_pkg.
module lesf_core
   import lesf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   input  logic [CELL_W-1:0] req_cell,
   output logic              req_ready,
   input  logic              out_hold,
   output res_type           res
);

   // raster position of the next accepted cell
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   // scoring stage
   logic             s1_valid_ff, s1_valid_in;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic             s1_free_ff;
   logic             s1_last_ff;

   logic [SCORE_W-1:0] up_ff;
   logic [SCORE_W-1:0] left_ff, left_in;
   logic [SCORE_W-1:0] diag_ff, diag_in;
   logic [SCORE_W-1:0] best_ff, best_in;
   logic [ROW_W-1:0]   best_row_ff, best_row_in;
   logic [COL_W-1:0]   best_col_ff, best_col_in;

   logic [SCORE_W-1:0] line_mem [MAX_COLS];

   logic               accept;
   logic               s1_fire;
   logic               last;
   logic [CCW-1:0]     col_nx;
   logic [RCW-1:0]     row_nx;
   logic [SCORE_W-1:0] min_a, min_b;
   logic [SCORE_W-1:0] score;
   logic               better;

   assign req_ready = !(s1_valid_ff && s1_last_ff && out_hold);
   assign accept    = req_valid && req_ready;
   assign s1_fire   = s1_valid_ff && !(s1_last_ff && out_hold);

   always_comb begin
      col_nx = CCW'(col_ff) + CCW'(1);
      row_nx = RCW'(row_ff);
      last   = 1'b0;
      col_in = col_ff;
      row_in = row_ff;
      if (col_nx >= cfg.cols) begin
         row_nx = RCW'(row_ff) + RCW'(1);
         if (row_nx >= cfg.rows) begin
            last = 1'b1;
         end
      end
      if (cfg.restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_nx >= cfg.cols) begin
            col_in = '0;
            row_in = last ? '0 : row_nx[ROW_W-1:0];
         end else begin
            col_in = col_nx[COL_W-1:0];
         end
      end
   end

   assign s1_valid_in = accept || (s1_valid_ff && !s1_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff  <= col_ff;
         s1_row_ff  <= row_ff;
         s1_free_ff <= (req_cell != cfg.obstacle);
         s1_last_ff <= last;
      end
   end

   // line store: read on accept, write back when the cell is scored.
   // Reads of the column being written only occur for one-column rows,
   // where the upper score is never used.
   always_ff @(posedge clock) begin
      if (accept) begin
         up_ff <= line_mem[col_ff];
      end
      if (s1_fire) begin
         line_mem[s1_col_ff] <= score;
      end
   end

   always_comb begin
      min_a = (up_ff < left_ff) ? up_ff : left_ff;
      min_b = (min_a < diag_ff) ? min_a : diag_ff;
      if (!s1_free_ff) begin
         score = '0;
      end else if (s1_row_ff == '0 || s1_col_ff == '0) begin
         score = SCORE_W'(1);
      end else begin
         score = min_b + SCORE_W'(1);
      end
      better = (score > best_ff);
   end

   always_comb begin
      left_in     = left_ff;
      diag_in     = diag_ff;
      best_in     = best_ff;
      best_row_in = best_row_ff;
      best_col_in = best_col_ff;
      if (cfg.restart) begin
         left_in     = '0;
         diag_in     = '0;
         best_in     = '0;
         best_row_in = '0;
         best_col_in = '0;
      end else if (s1_fire) begin
         left_in = score;
         diag_in = up_ff;
         if (s1_last_ff) begin
            best_in     = '0;
            best_row_in = '0;
            best_col_in = '0;
            left_in     = '0;
            diag_in     = '0;
         end else if (better) begin
            best_in     = score;
            best_row_in = ROW_W'(32'(s1_row_ff) + 32'd1 - 32'(score));
            best_col_in = COL_W'(32'(s1_col_ff) + 32'd1 - 32'(score));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff     <= '0;
         diag_ff     <= '0;
         best_ff     <= '0;
         best_row_ff <= '0;
         best_col_ff <= '0;
      end else begin
         left_ff     <= left_in;
         diag_ff     <= diag_in;
         best_ff     <= best_in;
         best_row_ff <= best_row_in;
         best_col_ff <= best_col_in;
      end
   end

   always_comb begin
      res.valid = s1_fire && s1_last_ff;
      if (better) begin
         res.size = score;
         res.row  = ROW_W'(32'(s1_row_ff) + 32'd1 - 32'(score));
         res.col  = COL_W'(32'(s1_col_ff) + 32'd1 - 32'(score));
      end else begin
         res.size = best_ff;
         res.row  = best_row_ff;
         res.col  = best_col_ff;
      end
   end

endmodule

// ----- rtl/largest_empty_square_finder.sv -----
// Largest empty square finder: one cell byte per beat in raster order, and
// after the last cell of the grid one result beat with the size and the
// top-left corner of the largest obstacle-free square (first found wins on
// ties, all zero if every cell is blocked). A cell is taken every cycle; the
// rate is set by the line store, which is read when a cell is taken and
// written back when it is scored, so reads and writes of a row overlap. The
// result is registered after the scoring stage; the input stalls only while
// a finished result waits and the next grid's last cell is ready to score.
// The line store needs no clearing after reset. Writing row_length or
// row_count restarts the grid; do so only while the block is idle.
// Depends on lesf_pkg and lesf_core.
module largest_empty_square_finder
   import lesf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CELL_W-1:0] req_cell_req,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [10:0]       rsp_square_size,
   output logic [9:0]        rsp_top_row,
   output logic [9:0]        rsp_left_col,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [CSR_W-1:0]  csr_wdata
);

   logic [CELL_W-1:0] obstacle_ff, obstacle_in;
   logic [CSR_W-1:0]  length_ff, length_in;
   logic [CSR_W-1:0]  count_ff, count_in;
   logic              restart;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [10:0] size_ff;
   logic [9:0]  top_ff;
   logic [9:0]  left_ff;

   cfg_type cfg;
   res_type res;
   logic    out_hold;

   always_comb begin
      obstacle_in = obstacle_ff;
      length_in   = length_ff;
      count_in    = count_ff;
      restart     = 1'b0;
      if (csr_we) begin
         case (csr_index)
            REG_OBSTACLE: begin
               obstacle_in = csr_wdata[CELL_W-1:0];
            end
            REG_ROW_LENGTH: begin
               length_in = csr_wdata;
               restart   = 1'b1;
            end
            REG_ROW_COUNT: begin
               count_in = csr_wdata;
               restart  = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         obstacle_ff <= OBSTACLE_RESET;
         length_ff   <= LENGTH_RESET;
         count_ff    <= COUNT_RESET;
      end else begin
         obstacle_ff <= obstacle_in;
         length_ff   <= length_in;
         count_ff    <= count_in;
      end
   end

   // effective geometry: zero acts as one, oversize saturates
   always_comb begin
      cfg.obstacle = obstacle_ff;
      cfg.restart  = restart;
      if (length_ff == '0) begin
         cfg.cols = CCW'(1);
      end else if (32'(length_ff) > MAX_COLS) begin
         cfg.cols = CCW'(MAX_COLS);
      end else begin
         cfg.cols = CCW'(length_ff);
      end
      if (count_ff == '0) begin
         cfg.rows = RCW'(1);
      end else if (32'(count_ff) > MAX_ROWS) begin
         cfg.rows = RCW'(MAX_ROWS);
      end else begin
         cfg.rows = RCW'(count_ff);
      end
   end

   assign out_hold = rsp_valid_ff && !rsp_ready;

   lesf_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_cell  (req_cell_req),
      .req_ready (req_ready),
      .out_hold  (out_hold),
      .res       (res)
   );

   assign rsp_valid_in = res.valid || out_hold;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res.valid) begin
         size_ff <= 11'(res.size);
         top_ff  <= 10'(res.row);
         left_ff <= 10'(res.col);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_square_size = size_ff;
   assign rsp_top_row     = top_ff;
   assign rsp_left_col    = left_ff;

endmodule

// ----- rtl/lesf_checker.sv -----
// Port-level checks of the largest empty square finder, bound to the top.
// Depends on lesf_pkg and largest_empty_square_finder_defines.svh.
`include "largest_empty_square_finder_defines.svh"

module lesf_checker
   import lesf_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [10:0] rsp_square_size,
   input logic [9:0]  rsp_top_row,
   input logic [9:0]  rsp_left_col
);

   `LESF_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `LESF_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready,
      $stable(rsp_square_size) && $stable(rsp_top_row) && $stable(rsp_left_col))
   // an empty result carries a zero corner
   `LESF_ASSERT_NOW(a_empty_corner, clock, reset, rsp_valid && rsp_square_size == 11'd0,
      rsp_top_row == 10'd0 && rsp_left_col == 10'd0)
   // the square fits inside the largest grid
   `LESF_ASSERT_NOW(a_square_fits, clock, reset, rsp_valid,
      (32'(rsp_top_row) + 32'(rsp_square_size) <= MAX_ROWS) &&
      (32'(rsp_left_col) + 32'(rsp_square_size) <= MAX_COLS))

endmodule

bind largest_empty_square_finder lesf_checker u_lesf_checker (.*);

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// Testbench for largest_empty_square_finder: streams grids of cell bytes and
// checks each result beat against an in-bench scoring model of the recurrence.
// Depends on lesf_pkg and the RTL of largest_empty_square_finder.
module tb;
   import lesf_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef struct {
      logic [10:0] size;
      logic [9:0]  row;
      logic [9:0]  col;
   } square_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [CELL_W-1:0] req_cell_req = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [10:0]       rsp_square_size;
   logic [9:0]        rsp_top_row;
   logic [9:0]        rsp_left_col;
   logic              csr_we = 1'b0;
   logic [1:0]        csr_index = '0;
   logic [CSR_W-1:0]  csr_wdata = '0;

   largest_empty_square_finder DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cell_req    (req_cell_req),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_square_size (rsp_square_size),
      .rsp_top_row     (rsp_top_row),
      .rsp_left_col    (rsp_left_col),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #6 clock = ~clock;

   // scoring model state
   logic [7:0]  obstacle_q = OBSTACLE_RESET;
   logic [10:0] length_q   = LENGTH_RESET;
   logic [10:0] count_q    = COUNT_RESET;
   logic [10:0] line_scores [0:MAX_COLS-1];
   logic [10:0] left_q, diag_q, col_q, row_q, best_size_q;
   logic [9:0]  best_row_q, best_col_q;

   square_type expected_squares [$];
   square_type want_sq;
   int      mismatch_count = 0;
   int      cycle_count = 0;
   int      burst_left = 0;
   int      random_cells = 0;
   int      grids_done = 0;

   logic [6:0] stall_phase = '0;
   logic [1:0] stall_mode = '0;

   function automatic logic [10:0] clamp_dim(input logic [10:0] v, input int lim);
      if (v == 11'd0)
         return 11'd1;
      if (v > lim)
         return lim[10:0];
      return v;
   endfunction

   task automatic clear_grid_state();
      left_q = '0;
      diag_q = '0;
      col_q = '0;
      row_q = '0;
      best_size_q = '0;
      best_row_q = '0;
      best_col_q = '0;
   endtask

   task automatic apply_reg(input logic [1:0] idx, input logic [10:0] data);
      if (idx == REG_OBSTACLE) begin
         obstacle_q = data[7:0];
      end else if (idx == REG_ROW_LENGTH) begin
         length_q = data;
         clear_grid_state();
      end else if (idx == REG_ROW_COUNT) begin
         count_q = data;
         clear_grid_state();
      end
   endtask

   task automatic score_cell(input logic [7:0] cell_byte);
      logic [10:0] cols, rows, c, r, up, score, m, corner;
      square_type sq;
      cols = clamp_dim(length_q, MAX_COLS);
      rows = clamp_dim(count_q, MAX_ROWS);
      c = col_q;
      r = row_q;
      up = line_scores[c[9:0]];
      if (cell_byte == obstacle_q) begin
         score = '0;
      end else if (r == 0 || c == 0) begin
         score = 11'd1;
      end else begin
         m = up;
         if (left_q < m) m = left_q;
         if (diag_q < m) m = diag_q;
         score = m + 11'd1;
      end
      diag_q = up;
      line_scores[c[9:0]] = score;
      left_q = score;
      if (score > best_size_q) begin
         best_size_q = score;
         corner = r + 11'd1 - score;
         best_row_q = corner[9:0];
         corner = c + 11'd1 - score;
         best_col_q = corner[9:0];
      end
      c = c + 11'd1;
      if (c >= cols) begin
         c = '0;
         r = r + 11'd1;
      end
      col_q = c;
      row_q = r;
      if (r >= rows) begin
         sq.size = best_size_q;
         sq.row = best_row_q;
         sq.col = best_col_q;
         expected_squares.push_back(sq);
         clear_grid_state();
      end
   endtask

   // one input beat; bursts of random length separated by random gaps
   task automatic send_cell(input logic [7:0] cell_byte);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_cell_req <= cell_byte;
      do @(posedge clock); while (!req_ready);
      score_cell(cell_byte);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [10:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      apply_reg(idx, data);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // stop sending, let every result arrive, then let the pipeline empty
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_squares.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_cell(input int density);
      if ($urandom_range(99) < density)
         return obstacle_q;
      return 8'($urandom_range(255));
   endfunction

   task automatic set_geometry(input logic [10:0] len, input logic [10:0] cnt);
      write_reg(REG_ROW_LENGTH, len);
      write_reg(REG_ROW_COUNT, cnt);
   endtask

   // default obstacle 111 and default geometry; a geometry write drops the open grid
   task automatic test_reset_values_and_restart();
      send_cell(8'd3);
      send_cell(8'd111);
      send_cell(8'd200);
      drain();
      set_geometry(11'd2, 11'd2);
      send_cell(8'd111);
      send_cell(8'd5);
      send_cell(8'd7);
      send_cell(8'd9);
      drain();
   endtask

   task automatic test_all_obstacles();
      write_reg(REG_OBSTACLE, 11'd0);
      for (int i = 0; i < 4; i++)
         send_cell(8'd0);
      drain();
   endtask

   task automatic test_zero_dims();
      write_reg(REG_OBSTACLE, 11'd255);
      set_geometry(11'd0, 11'd0);
      send_cell(8'd0);
      send_cell(8'd255);
      drain();
   endtask

   // two equal squares side by side: the first in raster order must win
   task automatic test_tie_break();
      write_reg(REG_OBSTACLE, 11'd0);
      set_geometry(11'd5, 11'd2);
      for (int r = 0; r < 2; r++)
         for (int c = 0; c < 5; c++)
            send_cell((c == 2) ? 8'd0 : 8'hff);
      drain();
   endtask

   task automatic test_obstacle_change_mid_grid();
      write_reg(REG_OBSTACLE, 11'd255);
      set_geometry(11'd2, 11'd2);
      send_cell(8'd0);
      send_cell(8'd7);
      drain();
      write_reg(REG_OBSTACLE, 11'd7);
      send_cell(8'd7);
      send_cell(8'd0);
      drain();
   endtask

   task automatic test_unknown_register();
      set_geometry(11'd1, 11'd1);
      write_reg(REG_UNUSED, 11'h7ff);
      send_cell(obstacle_q);
      drain();
   endtask

   task automatic test_random_grids();
      logic [10:0] len, cnt;
      int total, n, density;
      bit reshape;
      reshape = 1'b1;
      while (random_cells < 700 || grids_done < 20) begin
         drain();
         if ($urandom_range(1) == 0) begin
            case ($urandom_range(3))
               0: write_reg(REG_OBSTACLE, 11'd0);
               1: write_reg(REG_OBSTACLE, 11'd255);
               default: write_reg(REG_OBSTACLE, 11'($urandom_range(255)));
            endcase
         end
         if ($urandom_range(9) == 0)
            write_reg(REG_UNUSED, 11'($urandom_range(2047)));
         if (reshape || $urandom_range(4) != 0) begin
            case ($urandom_range(19))
               0, 1, 2: begin
                  len = 11'($urandom_range(2));
                  cnt = 11'($urandom_range(40));
               end
               3, 4: begin
                  len = 11'($urandom_range(9, 16));
                  cnt = 11'($urandom_range(9, 16));
               end
               default: begin
                  len = 11'($urandom_range(1, 8));
                  cnt = 11'($urandom_range(1, 8));
               end
            endcase
            set_geometry(len, cnt);
         end
         case ($urandom_range(5))
            0: density = 0;
            1: density = 5;
            2: density = 20;
            3: density = 50;
            4: density = 90;
            default: density = 100;
         endcase
         total = clamp_dim(length_q, MAX_COLS) * clamp_dim(count_q, MAX_ROWS);
         // a share of broken grids, cut short and restarted by a geometry write
         reshape = ($urandom_range(6) == 0) && (total > 1);
         n = reshape ? $urandom_range(1, total - 1) : total;
         for (int i = 0; i < n; i++)
            send_cell(pick_cell(density));
         random_cells += n;
         if (!reshape)
            grids_done++;
      end
      drain();
   endtask

   // receiver stall pattern, re-chosen each time the phase counter wraps
   always @(posedge clock) begin
      stall_phase <= stall_phase + 7'd1;
      if (stall_phase == 7'd0)
         stall_mode <= 2'($urandom_range(3));
      case (stall_mode)
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= 1'($urandom_range(1));
         2'd2: rsp_ready <= (stall_phase % 3 == 0);
         default: rsp_ready <= ($urandom_range(9) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_squares.size() == 0) begin
            $error("unexpected result beat: square_size %0d top_row %0d left_col %0d",
                   rsp_square_size, rsp_top_row, rsp_left_col);
            mismatch_count++;
         end else begin
            want_sq = expected_squares.pop_front();
            if (rsp_square_size !== want_sq.size) begin
               $error("square_size: expected %0d, actual %0d", want_sq.size, rsp_square_size);
               mismatch_count++;
            end
            if (rsp_top_row !== want_sq.row) begin
               $error("top_row: expected %0d, actual %0d", want_sq.row, rsp_top_row);
               mismatch_count++;
            end
            if (rsp_left_col !== want_sq.col) begin
               $error("left_col: expected %0d, actual %0d", want_sq.col, rsp_left_col);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < MAX_COLS; i++)
         line_scores[i] = '0;
      clear_grid_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values_and_restart();
      test_all_obstacles();
      test_zero_dims();
      test_tie_break();
      test_obstacle_change_mid_grid();
      test_unknown_register();
      test_random_grids();

      if (expected_squares.size() != 0) begin
         $error("%0d expected results never arrived", expected_squares.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/lesf_pkg.sv
rtl/lesf_core.sv
rtl/largest_empty_square_finder.sv
rtl/lesf_checker.sv
dv/tb.sv
